// ----- rtl/fwur_pkg.sv -----
// ============================================================================
// fwur_pkg
// Shared types and constants of the firmware update receiver.
// ============================================================================
`default_nettype none

package fwur_pkg;

    // boot phases
    localparam logic [3:0] PH_CHECK  = 4'd0;
    localparam logic [3:0] PH_WAIT   = 4'd1;
    localparam logic [3:0] PH_HEADER = 4'd2;
    localparam logic [3:0] PH_ERASE  = 4'd3;
    localparam logic [3:0] PH_IMAGE  = 4'd4;
    localparam logic [3:0] PH_WPEND  = 4'd5;
    localparam logic [3:0] PH_VERIFY = 4'd6;
    localparam logic [3:0] PH_JUMP   = 4'd7;
    localparam logic [3:0] PH_ERROR  = 4'd8;

    // event kinds
    localparam logic [2:0] EV_CHECK   = 3'd0;
    localparam logic [2:0] EV_PACKET  = 3'd1;
    localparam logic [2:0] EV_RXFAIL  = 3'd2;
    localparam logic [2:0] EV_FLASH   = 3'd3;
    localparam logic [2:0] EV_VERIFY  = 3'd4;
    localparam logic [2:0] EV_TIMEOUT = 3'd5;

    // flash commands
    localparam logic [1:0] FCMD_NONE  = 2'd0;
    localparam logic [1:0] FCMD_ERASE = 2'd1;
    localparam logic [1:0] FCMD_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_STACK_LOW     = 3'd0;
    localparam logic [2:0] REG_STACK_HIGH    = 3'd1;
    localparam logic [2:0] REG_IMAGE_BASE    = 3'd2;
    localparam logic [2:0] REG_HANDLER_LIMIT = 3'd3;
    localparam logic [2:0] REG_IMAGE_LIMIT   = 3'd4;
    localparam logic [2:0] REG_FRAME_MARK    = 3'd5;
    localparam logic [2:0] REG_IMAGE_MAGIC   = 3'd6;
    localparam logic [2:0] REG_PAYLOAD_LIMIT = 3'd7;

    // protocol constants
    localparam logic [15:0] HEADER_BYTES     = 16'd16;
    localparam logic [7:0]  CMD_START_UPDATE = 8'd1;
    localparam logic [7:0]  CMD_DATA         = 8'd2;

    typedef struct packed {
        logic [31:0] stack_low;
        logic [31:0] stack_high;
        logic [31:0] image_base;
        logic [31:0] handler_limit;
        logic [31:0] image_limit;
        logic [15:0] frame_marker;
        logic [31:0] image_magic_value;
        logic [15:0] payload_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] pkt_marker;
        logic [7:0]  pkt_command;
        logic [15:0] pkt_sequence;
        logic [15:0] pkt_length;
        logic        crc_ok;
        logic [31:0] hdr_image_size;
        logic [31:0] hdr_magic;
        logic [31:0] stack_word;
        logic [31:0] reset_word;
        logic        ok_flag;
    } t_item;

    typedef struct packed {
        logic [3:0]  phase;
        logic [15:0] expected_seq;
        logic [31:0] bytes_done;
        logic [31:0] next_address;
        logic [31:0] image_bytes;
        logic [15:0] pending_length;
        logic [15:0] pending_seq;
    } t_state;

    typedef struct packed {
        logic [3:0]  boot_state;
        logic        send_ack;
        logic        send_nack;
        logic [15:0] reply_sequence;
        logic [1:0]  flash_command;
        logic [31:0] flash_address;
        logic [15:0] flash_length;
        logic        start_verify;
        logic        start_jump;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/fwur_core.sv -----
// ============================================================================
// fwur_core
// One step of the update sequencer: next state and result for one event.
// ============================================================================
`default_nettype none

module fwur_core (
    input  wire fwur_pkg::t_cfg    i_cfg,
    input  wire fwur_pkg::t_state  i_state,
    input  wire fwur_pkg::t_item   i_item,
    output fwur_pkg::t_state       o_state,
    output fwur_pkg::t_result      o_result
);

    logic [31:0] reset_addr;
    logic        stack_ok;
    logic        reset_ok;
    logic        hdr_ok;
    logic [32:0] bytes_after;
    logic [31:0] bytes_new;
    logic        is_pkt;

    assign reset_addr = i_item.reset_word & ~32'd1;
    assign stack_ok   = (i_item.stack_word >= i_cfg.stack_low)
                      && (i_item.stack_word < i_cfg.stack_high);
    assign reset_ok   = (reset_addr >= i_cfg.image_base) && (reset_addr < i_cfg.handler_limit);
    assign hdr_ok     = (i_item.pkt_marker == i_cfg.frame_marker)
                      && (i_item.pkt_command == fwur_pkg::CMD_START_UPDATE)
                      && (i_item.pkt_length == fwur_pkg::HEADER_BYTES)
                      && (i_item.hdr_image_size != 32'd0)
                      && (i_item.hdr_magic == i_cfg.image_magic_value)
                      && (i_item.hdr_image_size <= i_cfg.image_limit);
    // 33-bit sum so the overflow check cannot wrap
    assign bytes_after = {1'b0, i_state.bytes_done} + {17'd0, i_item.pkt_length};
    assign bytes_new   = i_state.bytes_done + {16'd0, i_state.pending_length};
    assign is_pkt      = (i_item.req_type == fwur_pkg::EV_PACKET);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_state.phase)
            fwur_pkg::PH_CHECK: begin
                if (i_item.req_type == fwur_pkg::EV_CHECK) begin
                    o_state.phase = (stack_ok && reset_ok && i_item.ok_flag) ?
                                    fwur_pkg::PH_WAIT : fwur_pkg::PH_HEADER;
                end
            end
            fwur_pkg::PH_WAIT: begin
                if (is_pkt && i_item.pkt_command == fwur_pkg::CMD_START_UPDATE) begin
                    o_state.phase = fwur_pkg::PH_HEADER;
                end else if (is_pkt || i_item.req_type == fwur_pkg::EV_RXFAIL
                             || i_item.req_type == fwur_pkg::EV_TIMEOUT) begin
                    o_state.phase       = fwur_pkg::PH_JUMP;
                    o_result.start_jump = 1'b1;
                end
            end
            fwur_pkg::PH_HEADER: begin
                if (i_item.req_type == fwur_pkg::EV_RXFAIL) begin
                    o_state.phase = fwur_pkg::PH_ERROR;
                end else if (is_pkt) begin
                    if (!hdr_ok) begin
                        o_state.phase = fwur_pkg::PH_ERROR;
                    end else begin
                        o_result.send_ack       = 1'b1;
                        o_result.reply_sequence = i_item.pkt_sequence;
                        o_result.flash_command  = fwur_pkg::FCMD_ERASE;
                        o_result.flash_address  = i_cfg.image_base;
                        o_result.flash_length   = fwur_pkg::HEADER_BYTES;
                        o_state.image_bytes     = i_item.hdr_image_size;
                        o_state.next_address    = i_cfg.image_base
                                                + {16'd0, fwur_pkg::HEADER_BYTES};
                        o_state.bytes_done      = 32'd0;
                        o_state.expected_seq    = 16'd0;
                        o_state.phase           = fwur_pkg::PH_ERASE;
                    end
                end
            end
            fwur_pkg::PH_ERASE: begin
                if (i_item.req_type == fwur_pkg::EV_FLASH) begin
                    o_state.phase = i_item.ok_flag ? fwur_pkg::PH_IMAGE : fwur_pkg::PH_ERROR;
                end
            end
            fwur_pkg::PH_IMAGE: begin
                if (i_item.req_type == fwur_pkg::EV_RXFAIL) begin
                    o_state.phase = fwur_pkg::PH_ERROR;
                end else if (is_pkt) begin
                    if (i_item.pkt_marker != i_cfg.frame_marker) begin
                        o_result.send_nack      = 1'b1;
                        o_result.reply_sequence = i_item.pkt_sequence;
                    end else if (i_item.pkt_command != fwur_pkg::CMD_DATA) begin
                        o_state.phase = fwur_pkg::PH_ERROR;
                    end else if (i_item.pkt_sequence != i_state.expected_seq) begin
                        o_result.send_nack      = 1'b1;
                        o_result.reply_sequence = i_state.expected_seq;
                    end else if (i_item.pkt_length > i_cfg.payload_limit
                                 || bytes_after > {1'b0, i_state.image_bytes}) begin
                        o_state.phase = fwur_pkg::PH_ERROR;
                    end else if (!i_item.crc_ok) begin
                        o_result.send_nack      = 1'b1;
                        o_result.reply_sequence = i_item.pkt_sequence;
                    end else begin
                        o_result.flash_command = fwur_pkg::FCMD_WRITE;
                        o_result.flash_address = i_state.next_address;
                        o_result.flash_length  = i_item.pkt_length;
                        o_state.pending_length = i_item.pkt_length;
                        o_state.pending_seq    = i_item.pkt_sequence;
                        o_state.phase          = fwur_pkg::PH_WPEND;
                    end
                end
            end
            fwur_pkg::PH_WPEND: begin
                if (i_item.req_type == fwur_pkg::EV_FLASH) begin
                    if (!i_item.ok_flag) begin
                        o_state.phase = fwur_pkg::PH_ERROR;
                    end else begin
                        o_state.next_address    = i_state.next_address
                                                + {16'd0, i_state.pending_length};
                        o_state.bytes_done      = bytes_new;
                        o_state.expected_seq    = i_state.expected_seq + 16'd1;
                        o_result.send_ack       = 1'b1;
                        o_result.reply_sequence = i_state.pending_seq;
                        if (bytes_new >= i_state.image_bytes) begin
                            o_state.phase         = fwur_pkg::PH_VERIFY;
                            o_result.start_verify = 1'b1;
                        end else begin
                            o_state.phase = fwur_pkg::PH_IMAGE;
                        end
                    end
                end
            end
            fwur_pkg::PH_VERIFY: begin
                if (i_item.req_type == fwur_pkg::EV_VERIFY) begin
                    if (i_item.ok_flag) begin
                        o_state.phase       = fwur_pkg::PH_JUMP;
                        o_result.start_jump = 1'b1;
                    end else begin
                        o_state.phase = fwur_pkg::PH_ERROR;
                    end
                end
            end
            fwur_pkg::PH_JUMP, fwur_pkg::PH_ERROR: begin
                o_state.phase = i_state.phase;
            end
            default: begin
                o_state.phase = fwur_pkg::PH_ERROR;
            end
        endcase
        o_result.boot_state = o_state.phase;
    end

endmodule

`default_nettype wire

// ----- rtl/firmware_update_receiver.sv -----
// ============================================================================
// firmware_update_receiver
// Bootloader update sequencer driven by a stream of events, one result each.
// ============================================================================
// Each accepted event yields exactly one result. Events move through an input
// register, then the step logic updates the sequencer state and loads the
// result register, from which the result is presented; one event is taken
// every clock cycle while the result stream is not stalled, the rate being
// bounded otherwise only by the state update feeding the next event. A stalled
// result lets one more event wait in the input register before o_s_tready
// drops. The user must write configuration registers through the i_cfg_* port
// only while no event is in flight; the block itself does not enforce this.
`default_nettype none

module firmware_update_receiver (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // configuration
    input  wire          i_cfg_we,
    input  wire  [2:0]   i_cfg_idx,
    input  wire  [31:0]  i_cfg_data,
    // event stream
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // [15:0] pkt_marker, [23:16] pkt_command, [39:24] pkt_sequence,
    // [55:40] pkt_length, [56] crc_ok, [88:57] hdr_image_size,
    // [120:89] hdr_magic, [152:121] stack_word, [184:153] reset_word,
    // [185] ok_flag, [191:186] zero
    input  wire  [191:0] i_s_tdata,
    // [2:0] req_type
    input  wire  [2:0]   i_s_tuser,
    // result stream
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // [3:0] boot_state, [4] send_ack, [5] send_nack, [21:6] reply_sequence,
    // [23:22] flash_command, [55:24] flash_address, [71:56] flash_length,
    // [72] start_verify, [73] start_jump, [79:74] zero
    output logic [79:0]  o_m_tdata
);

    fwur_pkg::t_cfg    r_cfg;
    fwur_pkg::t_state  r_state;
    fwur_pkg::t_state  n_state;
    fwur_pkg::t_item   r_item;
    fwur_pkg::t_result r_res;
    fwur_pkg::t_result n_res;
    logic              r_in_vld;
    logic              r_out_vld;
    logic              advance;
    logic              s_accept;

    assign advance    = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    fwur_core u_core (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stack_low         <= 32'h2000_0000;
            r_cfg.stack_high        <= 32'h2000_5000;
            r_cfg.image_base        <= 32'h0800_4000;
            r_cfg.handler_limit     <= 32'h0801_0000;
            r_cfg.image_limit       <= 32'd49152;
            r_cfg.frame_marker      <= 16'd0;
            r_cfg.image_magic_value <= 32'd0;
            r_cfg.payload_limit     <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fwur_pkg::REG_STACK_LOW:     r_cfg.stack_low         <= i_cfg_data;
                fwur_pkg::REG_STACK_HIGH:    r_cfg.stack_high        <= i_cfg_data;
                fwur_pkg::REG_IMAGE_BASE:    r_cfg.image_base        <= i_cfg_data;
                fwur_pkg::REG_HANDLER_LIMIT: r_cfg.handler_limit     <= i_cfg_data;
                fwur_pkg::REG_IMAGE_LIMIT:   r_cfg.image_limit       <= i_cfg_data;
                fwur_pkg::REG_FRAME_MARK:    r_cfg.frame_marker      <= i_cfg_data[15:0];
                fwur_pkg::REG_IMAGE_MAGIC:   r_cfg.image_magic_value <= i_cfg_data;
                fwur_pkg::REG_PAYLOAD_LIMIT: r_cfg.payload_limit     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // control and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (s_accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_item.req_type       <= i_s_tuser;
            r_item.pkt_marker     <= i_s_tdata[15:0];
            r_item.pkt_command    <= i_s_tdata[23:16];
            r_item.pkt_sequence   <= i_s_tdata[39:24];
            r_item.pkt_length     <= i_s_tdata[55:40];
            r_item.crc_ok         <= i_s_tdata[56];
            r_item.hdr_image_size <= i_s_tdata[88:57];
            r_item.hdr_magic      <= i_s_tdata[120:89];
            r_item.stack_word     <= i_s_tdata[152:121];
            r_item.reset_word     <= i_s_tdata[184:153];
            r_item.ok_flag        <= i_s_tdata[185];
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0, r_res.start_jump, r_res.start_verify, r_res.flash_length,
                         r_res.flash_address, r_res.flash_command, r_res.reply_sequence,
                         r_res.send_nack, r_res.send_ack, r_res.boot_state};

`ifndef SYNTHESIS
    a_ack_nack_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_res.send_ack && r_res.send_nack))
        else $error("ack and nack raised together");

    a_fcmd_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_res.flash_command != 2'd3))
        else $error("illegal flash command");

    a_jump_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.start_jump) |-> (r_res.boot_state == fwur_pkg::PH_JUMP))
        else $error("jump request outside jump state");

    a_jump_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == fwur_pkg::PH_JUMP) |=> (r_state.phase == fwur_pkg::PH_JUMP))
        else $error("left jump state");

    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without a processed event");
`endif

endmodule

`default_nettype wire
